>>> rtl/rfple_pkg.sv
// ----------------------------------------------------------------------------
// rfple_pkg
// Shared types, codes and the color palette of the RGB fade/pulse engine.
// ----------------------------------------------------------------------------
package rfple_pkg;

  // command codes carried in the kind field
  localparam logic [2:0] KIND_SET   = 3'd0;
  localparam logic [2:0] KIND_FADE  = 3'd1;
  localparam logic [2:0] KIND_PULSE = 3'd2;
  localparam logic [2:0] KIND_PARTY = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;

  // engine modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_FADE   = 2'd1;
  localparam logic [1:0] MODE_PULSE  = 2'd2;
  localparam logic [1:0] MODE_PARTY  = 2'd3;

  // random generator: Galois, right shift
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'd44257;

  // number of stored palette colors
  localparam int PAL_STORED = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  second_red;
    logic [7:0]  second_green;
    logic [7:0]  second_blue;
    logic [15:0] step_delay;
  } item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] out_mode;
  } result_t;

  // status from the core: palette jump request and current mode
  typedef struct packed {
    logic       jump;
    logic [1:0] mode;
  } core_stat_t;

  // party palette
  function automatic rgb_t palette_color(input logic [3:0] idx);
    rgb_t c;
    unique case (idx)
      4'd0:    c = '{red: 8'd204, green: 8'd0,   blue: 8'd204};
      4'd1:    c = '{red: 8'd128, green: 8'd255, blue: 8'd0};
      4'd2:    c = '{red: 8'd102, green: 8'd102, blue: 8'd255};
      4'd3:    c = '{red: 8'd51,  green: 8'd255, blue: 8'd51};
      4'd4:    c = '{red: 8'd255, green: 8'd153, blue: 8'd51};
      4'd5:    c = '{red: 8'd153, green: 8'd51,  blue: 8'd255};
      4'd6:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      4'd7:    c = '{red: 8'd255, green: 8'd153, blue: 8'd255};
      4'd8:    c = '{red: 8'd0,   green: 8'd128, blue: 8'd255};
      4'd9:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

>>> rtl/rfple_if.sv
// ----------------------------------------------------------------------------
// rfple_if
// Valid/ready channels of the engine: command input, color result, seed write.
// ----------------------------------------------------------------------------
interface rfple_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  second_red;
  logic [7:0]  second_green;
  logic [7:0]  second_blue;
  logic [15:0] step_delay;

  modport source (output valid, kind, red, green, blue, second_red, second_green,
                  second_blue, step_delay, input ready);
  modport sink (input valid, kind, red, green, blue, second_red, second_green,
                second_blue, step_delay, output ready);
endinterface

interface rfple_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [1:0] out_mode;

  modport source (output valid, out_red, out_green, out_blue, out_mode, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_mode, output ready);
endinterface

interface rfple_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] random_seed;

  modport source (output valid, random_seed, input ready);
  modport sink (input valid, random_seed, output ready);
endinterface

>>> rtl/rfple_in_reg.sv
// ----------------------------------------------------------------------------
// rfple_in_reg
// Input register: captures one command word, holds it until the core takes it.
// ----------------------------------------------------------------------------
module rfple_in_reg
  import rfple_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rfple_in_if.sink   in_ch,
  input  logic       take,      // core consumes the held word this cycle
  output logic       s1_valid,
  output item_t      s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // room when empty or being drained
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{kind: in_ch.kind, red: in_ch.red, green: in_ch.green,
                  blue: in_ch.blue, second_red: in_ch.second_red,
                  second_green: in_ch.second_green, second_blue: in_ch.second_blue,
                  step_delay: in_ch.step_delay};
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> rtl/rfple_rng.sv
// ----------------------------------------------------------------------------
// rfple_rng
// Palette chooser: 16-bit LFSR, seed write port, modulo reduction, palette.
// ----------------------------------------------------------------------------
module rfple_rng
  import rfple_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 10
)
(
  input  logic        clk,
  input  logic        rst_n,
  rfple_cfg_if.sink   cfg_ch,
  input  core_stat_t  stat,       // jump advances the generator
  output rgb_t        pal_color   // color for the next jump
);

  // reciprocal for v / PALETTE_ENTRIES, exact for all 16-bit v
  localparam int          SH    = 21;
  localparam int          RECIP = ((2 ** SH) + PALETTE_ENTRIES - 1) / PALETTE_ENTRIES;
  localparam logic [21:0] RECIP_W = 22'(RECIP);
  localparam logic [20:0] PE_W    = 21'(PALETTE_ENTRIES);

  logic [15:0] lfsr_r, lfsr_nxt;
  logic [15:0] seed_v;
  logic [15:0] adv_v;
  logic [37:0] prod;
  logic [15:0] quot;
  logic [20:0] qp;
  logic [20:0] rem_full;
  logic [3:0]  rem;
  logic [3:0]  idx;

  assign cfg_ch.ready = 1'b1;

  // one LFSR step; zero state is forced to 1 first
  always_comb begin
    seed_v = (lfsr_r == 16'd0) ? 16'd1 : lfsr_r;
    if (seed_v[0]) begin
      adv_v = (seed_v >> 1) ^ LFSR_TAPS;
    end else begin
      adv_v = seed_v >> 1;
    end
  end

  // index = (adv % PALETTE_ENTRIES) % PAL_STORED
  always_comb begin
    prod     = 38'(adv_v) * 38'(RECIP_W);
    quot     = prod[SH+15:SH];
    qp       = 21'(quot) * PE_W;
    rem_full = 21'(adv_v) - qp;
    rem      = rem_full[3:0];
    idx      = (rem >= 4'(PAL_STORED)) ? rem - 4'(PAL_STORED) : rem;
  end

  assign pal_color = palette_color(idx);

  // seed write loads the generator directly
  always_comb begin
    lfsr_nxt = lfsr_r;
    priority if (cfg_ch.valid && cfg_ch.ready) begin
      lfsr_nxt = cfg_ch.random_seed;
    end else if (stat.jump) begin
      lfsr_nxt = adv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_RESET;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

>>> rtl/rfple_core.sv
// ----------------------------------------------------------------------------
// rfple_core
// Engine state and next-state logic: commands, countdown and color stepping.
// ----------------------------------------------------------------------------
module rfple_core
  import rfple_pkg::*;
#(
  parameter int DELAY_BITS = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,       // s1_item is consumed this cycle
  input  item_t      s1_item,
  input  rgb_t       pal_color,
  output core_stat_t stat,
  output result_t    res_nxt
);

  localparam int DW = DELAY_BITS;

  rgb_t                 cur_r, cur_nxt;
  rgb_t                 tgt_r, tgt_nxt;
  rgb_t                 sec_r, sec_nxt;
  logic [DW-1:0]        reload_r, reload_nxt;
  logic signed [DW:0]   cnt_r, cnt_nxt;
  logic [1:0]           mode_r, mode_nxt;

  logic [DW+15:0]       delay_ext;
  logic [DW-1:0]        delay_v;
  logic                 cnt_le0;
  logic signed [DW:0]   cnt_base;
  rgb_t                 stepped;
  rgb_t                 c1;
  rgb_t                 c2;
  logic                 jump;

  // one step of a channel toward its target
  function automatic logic [7:0] step_to(input logic [7:0] c, input logic [7:0] t);
    logic [7:0] r;
    priority if (c < t) begin
      r = c + 8'd1;
    end else if (c > t) begin
      r = c - 8'd1;
    end else begin
      r = c;
    end
    return r;
  endfunction

  // delay fitted to DELAY_BITS
  assign delay_ext = {{DW{1'b0}}, s1_item.step_delay};
  assign delay_v   = delay_ext[DW-1:0];

  assign c1 = '{red: s1_item.red, green: s1_item.green, blue: s1_item.blue};
  assign c2 = '{red: s1_item.second_red, green: s1_item.second_green,
                blue: s1_item.second_blue};

  assign cnt_le0 = cnt_r[DW] || (cnt_r == '0);
  assign stepped = '{red:   step_to(cur_r.red, tgt_r.red),
                     green: step_to(cur_r.green, tgt_r.green),
                     blue:  step_to(cur_r.blue, tgt_r.blue)};

  // next state
  always_comb begin
    cur_nxt    = cur_r;
    tgt_nxt    = tgt_r;
    sec_nxt    = sec_r;
    reload_nxt = reload_r;
    cnt_nxt    = cnt_r;
    mode_nxt   = mode_r;
    cnt_base   = cnt_r;
    jump       = 1'b0;
    unique case (s1_item.kind)
      KIND_SET: begin
        cur_nxt  = c1;
        mode_nxt = MODE_NORMAL;
      end
      KIND_FADE: begin
        tgt_nxt    = c1;
        reload_nxt = delay_v;
        cnt_nxt    = {1'b0, delay_v};
        mode_nxt   = MODE_FADE;
      end
      KIND_PULSE: begin
        tgt_nxt    = c1;
        sec_nxt    = c2;
        reload_nxt = delay_v;
        cnt_nxt    = {1'b0, delay_v};
        mode_nxt   = MODE_PULSE;
      end
      KIND_PARTY: begin
        mode_nxt = MODE_PARTY;
      end
      KIND_TICK: begin
        if (mode_r != MODE_NORMAL) begin
          if (cnt_le0) begin
            cur_nxt  = stepped;
            cnt_base = {1'b0, reload_r};
            // arrival handling per mode
            if (stepped == tgt_r) begin
              unique case (mode_r)
                MODE_FADE: begin
                  mode_nxt = MODE_NORMAL;
                end
                MODE_PULSE: begin
                  tgt_nxt = sec_r;
                  sec_nxt = stepped;
                end
                default: begin
                  jump    = 1'b1;
                  cur_nxt = pal_color;
                end
              endcase
            end
          end
          cnt_nxt = cnt_base - (DW + 1)'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      tgt_r    <= '0;
      sec_r    <= '0;
      reload_r <= '0;
      cnt_r    <= '0;
      mode_r   <= MODE_NORMAL;
    end else if (fire) begin
      cur_r    <= cur_nxt;
      tgt_r    <= tgt_nxt;
      sec_r    <= sec_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
      mode_r   <= mode_nxt;
    end
  end

  assign stat    = '{jump: jump && fire, mode: mode_r};
  assign res_nxt = '{out_red: cur_nxt.red, out_green: cur_nxt.green,
                     out_blue: cur_nxt.blue, out_mode: mode_nxt};

endmodule

>>> rtl/rfple_out_reg.sv
// ----------------------------------------------------------------------------
// rfple_out_reg
// Result register: holds one color word until the consumer takes it.
// ----------------------------------------------------------------------------
module rfple_out_reg
  import rfple_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rfple_out_if.source out_ch,
  input  logic        load,
  input  result_t     res_nxt,
  output logic        can_load   // register empty or draining
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_red   = res_r.out_red;
  assign out_ch.out_green = res_r.out_green;
  assign out_ch.out_blue  = res_r.out_blue;
  assign out_ch.out_mode  = res_r.out_mode;

endmodule

>>> rtl/rgb_fade_pulse_led_engine_top.sv
// ----------------------------------------------------------------------------
// rgb_fade_pulse_led_engine_top
// RGB LED color engine: set, fade, pulse and party modes driven by ticks.
//
//   channel | dir | payload                                        | handshake
//   in_ch   | in  | kind, red/green/blue, second_*, step_delay     | valid/ready
//   out_ch  | out | out_red, out_green, out_blue, out_mode         | valid/ready
//   cfg_ch  | in  | random_seed                                    | valid/ready
//
// One word per cycle unless out_ch stalls; path: input then result register.
// Work sits between the input register and the result register; the palette
// path (LFSR step, reciprocal modulo, palette lookup) is the longest one.
// Reset (synchronous rst_n) clears the color state; LFSR starts at 44257.
// A stall on out_ch holds the result register and back-pressures in_ch.
// cfg_ch is always ready; a seed write loads the LFSR at once.
// ----------------------------------------------------------------------------
module rgb_fade_pulse_led_engine_top
  import rfple_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 10,
  parameter int DELAY_BITS      = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  rfple_in_if.sink    in_ch,
  rfple_out_if.source out_ch,
  rfple_cfg_if.sink   cfg_ch
);

  logic       s1_valid;
  item_t      s1_item;
  logic       can_load;
  logic       fire;
  result_t    res_nxt;
  rgb_t       pal_color;
  core_stat_t stat;

  // core consumes the held word when the result register has room
  assign fire = s1_valid && can_load;

  rfple_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (fire),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  rfple_rng #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_rng (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .stat      (stat),
    .pal_color (pal_color)
  );

  rfple_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .s1_item   (s1_item),
    .pal_color (pal_color),
    .stat      (stat),
    .res_nxt   (res_nxt)
  );

  rfple_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .load     (fire),
    .res_nxt  (res_nxt),
    .can_load (can_load)
  );

`ifndef ASSERT_OFF
  // set red and blue show up in the next result, in normal mode
  a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_item.kind == KIND_SET) |=>
      (out_ch.valid && out_ch.out_mode == MODE_NORMAL &&
       out_ch.out_red == $past(s1_item.red) &&
       out_ch.out_blue == $past(s1_item.blue)))
    else $error("set color not reflected in result");

  // a held input word stays put until consumed
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !fire) |=> (s1_valid && $stable(s1_item)))
    else $error("input register lost or changed a word");

  // palette jumps only on a consumed tick in party mode
  a_jump_src: assert property (@(posedge clk) disable iff (!rst_n)
    stat.jump |-> (fire && s1_item.kind == KIND_TICK && stat.mode == MODE_PARTY))
    else $error("palette jump outside party tick");

  // a result stays pending across a stall with no new load
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !fire)
    else $error("result overwritten while stalled");
`endif

endmodule
